@@ src/brf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Types and codes shared by the byte ring FIFO modules.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int MODE_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int FCODE_W = 2;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 11;
    localparam int FLAG_W  = 4;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SETFLAG = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QDATA   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QSPACE  = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_WAIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_END  = 2'd2;

    // Flags that end the stream for the reader and for the writer
    localparam logic [FLAG_W-1:0] FLAGS_DATA_END  = 4'b1010;
    localparam logic [FLAG_W-1:0] FLAGS_SPACE_END = 4'b0101;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    typedef struct packed {
        logic               rd_hit;
        logic [STAT_W-1:0]  status;
        logic [CNT_W-1:0]   data_count;
        logic [CNT_W-1:0]   space_count;
        logic [FLAG_W-1:0]  flag_bits;
    } t_result;

endpackage

@@ src/brf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_in_if
// Request channel of the byte ring FIFO: valid/ready plus request fields.
// ----------------------------------------------------------------------------
interface brf_in_if;
    logic                         valid;
    logic                         ready;
    logic [brf_pkg::MODE_W-1:0]   mode;
    logic [brf_pkg::BYTE_W-1:0]   write_byte;
    logic [brf_pkg::FCODE_W-1:0]  flag_code;

    modport source (output valid, output mode, output write_byte, output flag_code,
                    input ready);
    modport sink   (input valid, input mode, input write_byte, input flag_code,
                    output ready);
endinterface

@@ src/brf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_out_if
// Result channel of the byte ring FIFO: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface brf_out_if;
    logic                         valid;
    logic                         ready;
    logic [brf_pkg::BYTE_W-1:0]   read_byte;
    logic [brf_pkg::STAT_W-1:0]   status;
    logic [brf_pkg::CNT_W-1:0]    data_count;
    logic [brf_pkg::CNT_W-1:0]    space_count;
    logic [brf_pkg::FLAG_W-1:0]   flag_bits;

    modport source (output valid, output read_byte, output status, output data_count,
                    output space_count, output flag_bits, input ready);
    modport sink   (input valid, input read_byte, input status, input data_count,
                    input space_count, input flag_bits, output ready);
endinterface

@@ src/byte_ring_fifo_with_end_flags_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_end_flags_top
// Circular byte FIFO with sticky end-of-stream and broken flags.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                           Handshake
//  i_in     in   mode, write_byte, flag_code                       valid/ready
//  o_out    out  read_byte, status, data_count, space_count,       valid/ready
//                flag_bits
//
//  One request per cycle while the result slot is empty or being taken.
//  Pointers, count and flags update in the accept cycle; the byte store is
//  read in that cycle and its registered data lands in the result in the
//  next cycle, together with the result register. A stalled result blocks
//  the next request only while it is not taken. Synchronous reset clears
//  pointers, count, flags and the result valid; the byte store is not cleared.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_end_flags_top #(
    parameter int DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    brf_in_if.sink        i_in,
    brf_out_if.source     o_out
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                        accept;
    logic                        r_out_valid;
    brf_pkg::t_mem_ctl           mem_ctl;
    logic [PW-1:0]               waddr, raddr;
    logic [brf_pkg::BYTE_W-1:0]  rdata;
    brf_pkg::t_result            result;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    brf_ctrl #(
        .DEPTH (DEPTH),
        .PW    (PW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_mode      (i_in.mode),
        .i_flag_code (i_in.flag_code),
        .o_mem_ctl   (mem_ctl),
        .o_waddr     (waddr),
        .o_raddr     (raddr),
        .o_result    (result)
    );

    brf_mem #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (i_in.write_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_byte   = result.rd_hit ? rdata : '0;
    assign o_out.status      = result.status;
    assign o_out.data_count  = result.data_count;
    assign o_out.space_count = result.space_count;
    assign o_out.flag_bits   = result.flag_bits;

`ifndef SYNTHESIS
    a_counts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (DEPTH < 2048)) |->
        ((12'(o_out.data_count) + 12'(o_out.space_count)) == 12'(DEPTH)))
        else $error("data and space counts do not add up to depth");

    a_byte_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.read_byte != '0)) |-> (o_out.status == brf_pkg::ST_OK))
        else $error("byte returned on a refused request");

    a_flags_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_out.valid) && o_out.valid) |->
        ((o_out.flag_bits & $past(o_out.flag_bits)) == $past(o_out.flag_bits)))
        else $error("sticky flag cleared");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out.valid) |-> i_in.ready)
        else $error("request blocked with empty result slot");
`endif

endmodule

@@ src/brf_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brf_mem #(
    parameter int DEPTH = 1024,
    parameter int PW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  brf_pkg::t_mem_ctl           i_ctl,
    input  logic [PW-1:0]               i_waddr,
    input  logic [brf_pkg::BYTE_W-1:0]  i_wdata,
    input  logic [PW-1:0]               i_raddr,
    output logic [brf_pkg::BYTE_W-1:0]  o_rdata
);

    logic [brf_pkg::BYTE_W-1:0] r_store [DEPTH];
    logic [brf_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_store[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read so a stalled result keeps its byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_store[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/brf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ctrl
// Pointers, fill count and sticky flags; issues store accesses and builds
// the registered result of each request.
// ----------------------------------------------------------------------------
module brf_ctrl #(
    parameter int DEPTH = 1024,
    parameter int PW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [brf_pkg::MODE_W-1:0]   i_mode,
    input  logic [brf_pkg::FCODE_W-1:0]  i_flag_code,
    output brf_pkg::t_mem_ctl            o_mem_ctl,
    output logic [PW-1:0]                o_waddr,
    output logic [PW-1:0]                o_raddr,
    output brf_pkg::t_result             o_result
);

    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [PW-1:0]               r_wptr, n_wptr;
    logic [PW-1:0]               r_rptr, n_rptr;
    logic [CW-1:0]               r_held, n_held;
    logic [brf_pkg::FLAG_W-1:0]  r_flags, n_flags;
    brf_pkg::t_result            r_result, n_result;
    logic                        full, empty;

    assign full  = (r_held == CNT_FULL);
    assign empty = (r_held == '0);

    always_comb begin
        n_wptr          = r_wptr;
        n_rptr          = r_rptr;
        n_held          = r_held;
        n_flags         = r_flags;
        o_mem_ctl       = '0;
        n_result.rd_hit = 1'b0;
        n_result.status = brf_pkg::ST_OK;
        case (i_mode)
            brf_pkg::MODE_WRITE: begin
                if (!full) begin
                    o_mem_ctl.we = i_accept;
                    n_wptr       = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
                    n_held       = r_held + 1'b1;
                end else begin
                    n_result.status = brf_pkg::ST_WAIT;
                end
            end
            brf_pkg::MODE_READ: begin
                if (!empty) begin
                    o_mem_ctl.re    = i_accept;
                    n_result.rd_hit = 1'b1;
                    n_rptr          = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
                    n_held          = r_held - 1'b1;
                end else begin
                    n_result.status = brf_pkg::ST_WAIT;
                end
            end
            brf_pkg::MODE_SETFLAG: begin
                n_flags = r_flags | (brf_pkg::FLAG_W'(1) << i_flag_code);
            end
            brf_pkg::MODE_QDATA: begin
                if (!empty) begin
                    n_result.status = brf_pkg::ST_OK;
                end else if ((r_flags & brf_pkg::FLAGS_DATA_END) != '0) begin
                    n_result.status = brf_pkg::ST_END;
                end else begin
                    n_result.status = brf_pkg::ST_WAIT;
                end
            end
            brf_pkg::MODE_QSPACE: begin
                if ((r_flags & brf_pkg::FLAGS_SPACE_END) != '0) begin
                    n_result.status = brf_pkg::ST_END;
                end else if (!full) begin
                    n_result.status = brf_pkg::ST_OK;
                end else begin
                    n_result.status = brf_pkg::ST_WAIT;
                end
            end
            default: begin
            end
        endcase
        n_result.data_count  = brf_pkg::CNT_W'(n_held);
        n_result.space_count = brf_pkg::CNT_W'(CNT_FULL - n_held);
        n_result.flag_bits   = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_held  <= '0;
            r_flags <= '0;
        end else if (i_accept) begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_held  <= n_held;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_result <= n_result;
        end
    end

    assign o_waddr  = r_wptr;
    assign o_raddr  = r_rptr;
    assign o_result = r_result;

endmodule

@@ bench/byte_ring_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_checker
// Watches the request and result channels of the byte ring FIFO, keeps its
// own copy of the ring, pointers, occupancy and sticky flags, and compares
// every result against the outcome predicted for the matching request.
// ----------------------------------------------------------------------------
module byte_ring_checker #(
    parameter int DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    brf_in_if    i_req,
    brf_out_if   i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_compared,
    output int   o_wait_count,
    output int   o_end_count
);

    localparam int PTR_W = $clog2(DEPTH);

    typedef struct packed {
        logic [brf_pkg::BYTE_W-1:0] read_byte;
        logic [brf_pkg::STAT_W-1:0] status;
        logic [brf_pkg::CNT_W-1:0]  data_count;
        logic [brf_pkg::CNT_W-1:0]  space_count;
        logic [brf_pkg::FLAG_W-1:0] flag_bits;
    } t_ring_result;

    logic [brf_pkg::BYTE_W-1:0] ring_bytes [DEPTH];
    logic [PTR_W-1:0]           head_ptr;
    logic [PTR_W-1:0]           tail_ptr;
    logic [brf_pkg::CNT_W-1:0]  fill_level;
    logic [brf_pkg::FLAG_W-1:0] sticky;
    t_ring_result               awaited_results [$];

    int errors   = 0;
    int compared = 0;
    int waits    = 0;
    int ends     = 0;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Apply one request to the shadow ring and return the outcome it should produce.
    task automatic ring_access(input  logic [brf_pkg::MODE_W-1:0]  mode,
                               input  logic [brf_pkg::BYTE_W-1:0]  wbyte,
                               input  logic [brf_pkg::FCODE_W-1:0] fcode,
                               output t_ring_result                res);
        res = '0;
        case (mode)
            brf_pkg::MODE_WRITE: begin
                if (fill_level < brf_pkg::CNT_W'(DEPTH)) begin
                    ring_bytes[head_ptr] = wbyte;
                    head_ptr   = next_ptr(head_ptr);
                    fill_level = fill_level + 1'b1;
                end else begin
                    res.status = brf_pkg::ST_WAIT;
                end
            end
            brf_pkg::MODE_READ: begin
                if (fill_level != '0) begin
                    res.read_byte = ring_bytes[tail_ptr];
                    tail_ptr   = next_ptr(tail_ptr);
                    fill_level = fill_level - 1'b1;
                end else begin
                    res.status = brf_pkg::ST_WAIT;
                end
            end
            brf_pkg::MODE_SETFLAG: begin
                sticky = sticky | (brf_pkg::FLAG_W'(1) << fcode);
            end
            brf_pkg::MODE_QDATA: begin
                if (fill_level != '0)
                    res.status = brf_pkg::ST_OK;
                else if ((sticky & brf_pkg::FLAGS_DATA_END) != '0)
                    res.status = brf_pkg::ST_END;
                else
                    res.status = brf_pkg::ST_WAIT;
            end
            brf_pkg::MODE_QSPACE: begin
                if ((sticky & brf_pkg::FLAGS_SPACE_END) != '0)
                    res.status = brf_pkg::ST_END;
                else if (fill_level < brf_pkg::CNT_W'(DEPTH))
                    res.status = brf_pkg::ST_OK;
                else
                    res.status = brf_pkg::ST_WAIT;
            end
            default: begin
                // unused modes leave the ring alone
            end
        endcase
        res.data_count  = fill_level;
        res.space_count = brf_pkg::CNT_W'(DEPTH) - fill_level;
        res.flag_bits   = sticky;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_ring_result want;
        t_ring_result got;
        if (!i_rst_n) begin
            head_ptr   = '0;
            tail_ptr   = '0;
            fill_level = '0;
            sticky     = '0;
            awaited_results.delete();
        end else begin
            // Retire the oldest expectation before adding this cycle's request.
            if (i_res.valid && i_res.ready) begin
                got.read_byte   = i_res.read_byte;
                got.status      = i_res.status;
                got.data_count  = i_res.data_count;
                got.space_count = i_res.space_count;
                got.flag_bits   = i_res.flag_bits;
                if (awaited_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("read_byte", want.read_byte, got.read_byte);
                    check_field("status", want.status, got.status);
                    check_field("data_count", want.data_count, got.data_count);
                    check_field("space_count", want.space_count, got.space_count);
                    check_field("flag_bits", want.flag_bits, got.flag_bits);
                    compared++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                ring_access(i_req.mode, i_req.write_byte, i_req.flag_code, want);
                if (want.status == brf_pkg::ST_WAIT)
                    waits++;
                if (want.status == brf_pkg::ST_END)
                    ends++;
                awaited_results.push_back(want);
            end
        end
        o_errors     <= errors;
        o_pending    <= awaited_results.size();
        o_compared   <= compared;
        o_wait_count <= waits;
        o_end_count  <= ends;
    end

endmodule

@@ bench/byte_ring_fifo_with_end_flags_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_end_flags_top_tb
// Drives byte writes, reads, flag sets and availability queries into the
// byte ring FIFO under changing back-pressure, fills the ring to the top and
// drains it to empty, then sets the sticky flags; results are checked by
// byte_ring_checker.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_end_flags_top_tb;
    import brf_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int HOLD_CYCLES = 64;

    localparam logic [FCODE_W-1:0] FLAG_END_DATA   = 2'd0;
    localparam logic [FCODE_W-1:0] FLAG_END_XFER   = 2'd1;
    localparam logic [FCODE_W-1:0] FLAG_RD_BROKEN  = 2'd2;
    localparam logic [FCODE_W-1:0] FLAG_WR_BROKEN  = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    brf_in_if  in_ch ();
    brf_out_if out_ch ();

    int errors;
    int pending;
    int compared;
    int waits;
    int ends;

    int src_idle_pct  = 23;
    int sink_idle_pct = 55;
    int hold_request  = 0;
    int level         = 0;
    int sent          = 0;

    always #4 i_clk = ~i_clk;

    byte_ring_fifo_with_end_flags_top #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    byte_ring_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (in_ch),
        .i_res        (out_ch),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_compared   (compared),
        .o_wait_count (waits),
        .o_end_count  (ends)
    );

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when one is asked for.
    initial begin : sink_side
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic put_req(input logic [MODE_W-1:0]  m,
                           input logic [BYTE_W-1:0]  b,
                           input logic [FCODE_W-1:0] f);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= m;
        in_ch.write_byte <= b;
        in_ch.flag_code  <= f;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sent++;
        // track occupancy only to steer the fill and drain runs
        if (m == MODE_WRITE && level < DEPTH)
            level++;
        else if (m == MODE_READ && level > 0)
            level--;
    endtask

    task automatic put_mix(input int n, input int wr_pct, input int rd_pct,
                           input int flag_pct);
        int pick;
        logic [BYTE_W-1:0]  b;
        logic [FCODE_W-1:0] f;
        repeat (n) begin
            pick = $urandom_range(99);
            b    = BYTE_W'($urandom);
            f    = FCODE_W'($urandom);
            if (pick < wr_pct)
                put_req(MODE_WRITE, b, f);
            else if (pick < wr_pct + rd_pct)
                put_req(MODE_READ, b, f);
            else if (pick < wr_pct + rd_pct + flag_pct)
                put_req(MODE_SETFLAG, b, f);
            else begin
                case ($urandom_range(3))
                    0:       put_req(MODE_QDATA, b, f);
                    1:       put_req(MODE_QSPACE, b, f);
                    default: put_req(MODE_W'(int'(MODE_QSPACE) + $urandom_range(1, 3)), b, f);
                endcase
            end
        end
    endtask

    // Drop valid and hold until every outstanding result has been taken.
    task automatic wait_settled();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_WRITE;
        in_ch.write_byte <= '0;
        in_ch.flag_code  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty ring, byte extremes, every unused mode, read back in order.
        put_req(MODE_QDATA, 8'h00, '0);
        put_req(MODE_QSPACE, 8'h00, '0);
        put_req(MODE_READ, 8'hFF, '1);
        put_req(MODE_WRITE, 8'h00, '0);
        put_req(MODE_WRITE, 8'hFF, '1);
        put_req(MODE_WRITE, 8'h55, '0);
        put_req(MODE_WRITE, 8'hAA, '1);
        put_req(MODE_QDATA, 8'hFF, '1);
        for (int m = int'(MODE_QSPACE) + 1; m < 2 ** MODE_W; m++)
            put_req(MODE_W'(m), 8'hFF, '1);
        repeat (4) put_req(MODE_READ, 8'h00, '0);
        put_req(MODE_READ, 8'h00, '0);
        put_req(MODE_QDATA, 8'h00, '0);
        put_req(MODE_QSPACE, 8'hFF, '1);

        // Sender idles lightly, receiver heavily: walk around empty, then fill.
        put_mix(100, 50, 40, 0);
        while (level < DEPTH)
            put_mix(1, 88, 4, 0);
        repeat (3) put_req(MODE_WRITE, BYTE_W'($urandom), FCODE_W'($urandom));
        put_req(MODE_QSPACE, BYTE_W'($urandom), FCODE_W'($urandom));
        put_req(MODE_QDATA, BYTE_W'($urandom), FCODE_W'($urandom));
        wait_settled();

        // Roles swapped; open with a long receiver hold so the input stalls.
        src_idle_pct  = 55;
        sink_idle_pct = 23;
        hold_request  = HOLD_CYCLES;
        put_mix(200, 45, 45, 0);
        while (level > 0)
            put_mix(1, 4, 88, 0);
        repeat (3) put_req(MODE_READ, BYTE_W'($urandom), FCODE_W'($urandom));
        put_req(MODE_QDATA, BYTE_W'($urandom), FCODE_W'($urandom));
        put_req(MODE_QSPACE, BYTE_W'($urandom), FCODE_W'($urandom));

        // No idling: bring in the sticky flags one at a time.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        put_req(MODE_SETFLAG, 8'h00, FLAG_RD_BROKEN);
        put_req(MODE_QSPACE, 8'h00, '0);
        put_req(MODE_QDATA, 8'h00, '0);
        put_req(MODE_WRITE, 8'h3C, '0);
        put_req(MODE_WRITE, 8'hC3, '0);
        put_req(MODE_SETFLAG, 8'h00, FLAG_END_XFER);
        put_req(MODE_QDATA, 8'h00, '0);
        put_req(MODE_READ, 8'h00, '0);
        put_req(MODE_READ, 8'h00, '0);
        put_req(MODE_QDATA, 8'h00, '0);
        put_req(MODE_READ, 8'h00, '0);
        put_req(MODE_SETFLAG, 8'h00, FLAG_END_DATA);
        put_req(MODE_SETFLAG, 8'h00, FLAG_WR_BROKEN);
        put_req(MODE_SETFLAG, 8'h00, FLAG_END_DATA);
        put_req(MODE_QSPACE, 8'h00, '0);
        put_mix(150, 40, 40, 6);

        wait_settled();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d requests, compared %0d results (%0d would-wait, %0d ended).",
                 sent, compared, waits, ends);
        $display("Ring of %0d bytes filled to the top, drained to empty, all flags set.",
                 DEPTH);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
